>>> design/kfr_pkg.sv
`default_nettype none

package kfr_pkg;

    // Payload buffer size; byte counter width follows from it
    localparam int PAYLOAD_BYTES = 1024;
    localparam int COUNT_W       = $clog2(PAYLOAD_BYTES + 1);

    localparam logic [7:0] CH_FEND  = 8'hC0;
    localparam logic [7:0] CH_FESC  = 8'hDB;
    localparam logic [7:0] CH_TFEND = 8'hDC;
    localparam logic [7:0] CH_TFESC = 8'hDD;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;

    localparam logic [CFG_INDEX_W-1:0] REG_ENABLE         = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WAIT_FOR_START = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_PORT       = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_COMMAND_COUNT  = 2'd3;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    localparam int TDATA_W = 40;

    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_TYPE  = 2'd1,
        PH_DATA  = 2'd2,
        PH_FLUSH = 2'd3
    } phase_t;

    typedef struct packed {
        logic       enable;
        logic       wait_for_start;
        logic [3:0] max_port;
        logic [4:0] command_count;
    } cfg_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [9:0]  byte_offset;
        logic [3:0]  command_type;
        logic [3:0]  port_number;
        logic [10:0] frame_length;
        logic        overflowed;
    } result_t;

endpackage

`default_nettype wire

>>> design/kfr_cfg_regs.sv
`default_nettype none

module kfr_cfg_regs (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_write,
    input  wire logic [kfr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [kfr_pkg::CFG_DATA_W-1:0]  cfg_data,
    output kfr_pkg::cfg_t                       cfg
);
    import kfr_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_write) begin
            case (cfg_index)
                REG_ENABLE:         cfg_next.enable         = cfg_data[0];
                REG_WAIT_FOR_START: cfg_next.wait_for_start = cfg_data[0];
                REG_MAX_PORT:       cfg_next.max_port       = cfg_data[3:0];
                REG_COMMAND_COUNT:  cfg_next.command_count  = cfg_data[4:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable         <= 1'b0;
            cfg_reg.wait_for_start <= 1'b1;
            cfg_reg.max_port       <= 4'd1;
            cfg_reg.command_count  <= 5'd15;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> design/kfr_parser.sv
`default_nettype none

module kfr_parser (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire kfr_pkg::cfg_t cfg,
    input  wire logic       step,
    input  wire logic [7:0] rx_byte,
    output logic            res_valid,
    output kfr_pkg::result_t res
);
    import kfr_pkg::*;

    phase_t             phase_reg,    phase_next;
    logic               esc_reg,      esc_next;
    logic [3:0]         type_reg,     type_next;
    logic [3:0]         port_reg,     port_next;
    logic [COUNT_W-1:0] count_reg,    count_next;
    logic               ovf_reg,      ovf_next;

    logic   [7:0] c;
    logic         delim;
    logic         is_data;
    phase_t       home;

    // Unescape: a byte after FESC is always data
    always_comb begin
        c       = rx_byte;
        delim   = 1'b0;
        is_data = 1'b1;
        if (esc_reg) begin
            if (rx_byte == CH_TFEND) begin
                c = CH_FEND;
            end else if (rx_byte == CH_TFESC) begin
                c = CH_FESC;
            end
        end else if (rx_byte == CH_FESC) begin
            is_data = 1'b0;
        end else if (rx_byte == CH_FEND) begin
            delim = 1'b1;
        end
        home = cfg.wait_for_start ? PH_START : PH_TYPE;
    end

    // Next state
    always_comb begin
        phase_next = phase_reg;
        esc_next   = esc_reg;
        type_next  = type_reg;
        port_next  = port_reg;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (step && cfg.enable) begin
            esc_next = !is_data;
            if (is_data) begin
                case (phase_reg)
                    PH_START: begin
                        if (delim) begin
                            phase_next = PH_TYPE;
                        end
                    end
                    PH_TYPE: begin
                        if (!delim) begin
                            type_next  = c[3:0];
                            port_next  = c[7:4];
                            count_next = '0;
                            ovf_next   = 1'b0;
                            if (c[7:4] > cfg.max_port
                                    || {1'b0, c[3:0]} >= cfg.command_count) begin
                                phase_next = PH_FLUSH;
                            end else begin
                                phase_next = PH_DATA;
                            end
                        end
                    end
                    PH_DATA: begin
                        if (delim) begin
                            phase_next = home;
                        end else if (count_reg < COUNT_W'(PAYLOAD_BYTES)) begin
                            count_next = count_reg + COUNT_W'(1);
                        end else begin
                            ovf_next = 1'b1;
                        end
                    end
                    default: begin
                        if (delim) begin
                            phase_next = home;
                        end
                    end
                endcase
            end
        end
    end

    // Result
    always_comb begin
        res_valid        = 1'b0;
        res.kind         = KIND_PAYLOAD;
        res.data_byte    = c;
        res.byte_offset  = 10'(count_reg);
        res.command_type = type_reg;
        res.port_number  = port_reg;
        res.frame_length = '0;
        res.overflowed   = 1'b0;
        if (delim) begin
            res.kind         = KIND_END;
            res.data_byte    = '0;
            res.byte_offset  = '0;
            res.frame_length = 11'(count_reg);
            res.overflowed   = ovf_reg;
        end
        if (step && cfg.enable && is_data && phase_reg == PH_DATA) begin
            res_valid = delim || (count_reg < COUNT_W'(PAYLOAD_BYTES));
        end
    end

    // wait_for_start resets to 1, so the reset phase is always start
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_START;
            esc_reg   <= 1'b0;
            type_reg  <= '0;
            port_reg  <= '0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            esc_reg   <= esc_next;
            type_reg  <= type_next;
            port_reg  <= port_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

`default_nettype wire

>>> design/kiss_frame_receiver.sv
// A result passes from the input register through the parse step into the result
// register, and can be taken from m_ once it sits in the result register.
// Throughput: one byte per cycle, sustained while m_tready stays high.
// The parse step (unescape, phase decode, counter) sits between the input
// register and the result register; a full result register with m_tready
// low stalls it, and stalls the input register too once that holds a byte.
// Reset (aresetn low, synchronous): registers to their defaults (disabled,
// wait for start), parser to the start phase, both pipeline registers empty.
`default_nettype none

module kiss_frame_receiver (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // input byte stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [7:0]                      s_tdata,   // [7:0] rx_byte
    // result stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [7:0] data_byte, [17:8] byte_offset, [21:18] command_type,
    // [25:22] port_number, [36:26] frame_length, [37] overflowed, [39:38] zero
    output logic [kfr_pkg::TDATA_W-1:0]          m_tdata,
    output logic                                 m_tuser,   // [0] kind
    // register writes
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [kfr_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [kfr_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import kfr_pkg::*;

    cfg_t    cfg;
    result_t res;
    logic    res_valid;

    // input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    // result register
    logic       out_valid_reg;
    result_t    out_reg;

    logic out_free;
    logic advance;

    // The result register can take a new request when empty or being drained
    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;

    kfr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_write (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    kfr_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .step      (advance),
        .rx_byte   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= advance && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {2'b00, out_reg.overflowed, out_reg.frame_length,
                       out_reg.port_number, out_reg.command_type,
                       out_reg.byte_offset, out_reg.data_byte};

    // A held input byte behind a stalled result must block new requests
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_valid_reg && !m_tready |-> !s_tready)
        else $error("input accepted while pipeline stalled");

    // Frame-end length never exceeds the buffer size
    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_END
            |-> 32'(m_tdata[36:26]) <= PAYLOAD_BYTES)
        else $error("frame length beyond buffer size");

    // Payload results carry no length and no overflow flag
    a_payload_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_PAYLOAD
            |-> m_tdata[37:26] == 12'd0)
        else $error("payload result with frame-end fields set");

    // A new result only follows a byte held in the input register in the previous cycle
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(in_valid_reg))
        else $error("result without a source byte");

endmodule

`default_nettype wire
